FILE: hdl/ksl_pkg.sv
`timescale 1ns / 1ps

package ksl_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [TickW-1:0] HoldMax          = {TickW{1'b1}};
  localparam logic [TickW-1:0] LongPressReset   = 16'd1000;
  localparam logic [TickW-1:0] DoubleWindowReset = 16'd400;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgLongPress    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgDoubleWindow = 8'd1;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UP     = 3'd1,
    EV_DOWN   = 3'd2,
    EV_OK     = 3'd3,
    EV_PUSH   = 3'd4,
    EV_DOUBLE = 3'd5
  } ev_e;

  // Key levels already turned active high: 1 means the key is pressed.
  typedef struct packed {
    logic up;
    logic down;
    logic ok;
    logic push;
  } keys_t;

  typedef struct packed {
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] double_press_window;
  } cfg_t;

  typedef struct packed {
    ev_e  event_code;
    logic save_request;
  } result_t;

endpackage

FILE: hdl/ksl_if.sv
`timescale 1ns / 1ps

interface ksl_key_if;
  logic valid;
  logic ready;
  logic up_key_n;
  logic down_key_n;
  logic ok_key_n;
  logic push_key_n;

  modport source (output valid, up_key_n, down_key_n, ok_key_n, push_key_n, input ready);
  modport sink   (input valid, up_key_n, down_key_n, ok_key_n, push_key_n, output ready);
endinterface

interface ksl_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       save_request;

  modport source (output valid, event_code, save_request, input ready);
  modport sink   (input valid, event_code, save_request, output ready);
endinterface

interface ksl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ksl_cfg_regs.sv
`timescale 1ns / 1ps

module ksl_cfg_regs
  import ksl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ksl_cfg_if.sink     cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes always complete in one beat; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == CfgLongPress) begin
        cfg_d.long_press_ticks = cfg_i.data;
      end else if (cfg_i.index == CfgDoubleWindow) begin
        cfg_d.double_press_window = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= LongPressReset;
      cfg_q.double_press_window <= DoubleWindowReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/ksl_core.sv
`timescale 1ns / 1ps

module ksl_core
  import ksl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  keys_t   keys_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic             key_down_q, key_down_d;
  logic [TickW-1:0] hold_q, hold_d;
  logic [TickW-1:0] window_q, window_d;

  logic             any_key;
  logic             hold_rises;
  logic [TickW-1:0] hold_inc;
  logic [TickW-1:0] window_mid;
  logic             at_limit;

  assign any_key    = keys_i.up | keys_i.down | keys_i.ok | keys_i.push;
  assign hold_rises = (hold_q != HoldMax);
  assign hold_inc   = hold_rises ? hold_q + 16'd1 : hold_q;
  assign at_limit   = hold_rises && (hold_inc == cfg_i.long_press_ticks);

  always_comb begin
    key_down_d        = key_down_q;
    hold_d            = hold_q;
    window_mid        = window_q;
    res_o.event_code   = EV_NONE;
    res_o.save_request = 1'b0;

    if (!key_down_q && any_key) begin
      key_down_d = 1'b1;
      if (keys_i.up) begin
        res_o.event_code = EV_UP;
      end else if (keys_i.down) begin
        res_o.event_code = EV_DOWN;
      end else if (keys_i.ok) begin
        res_o.event_code = EV_OK;
      end else if (window_q != '0) begin
        // Second push hit inside the window closes it.
        res_o.event_code = EV_DOUBLE;
        window_mid       = '0;
      end else begin
        res_o.event_code = EV_PUSH;
        window_mid       = cfg_i.double_press_window;
      end
    end else if (key_down_q) begin
      if (keys_i.up) begin
        hold_d             = hold_inc;
        res_o.save_request = (hold_inc > cfg_i.long_press_ticks);
      end else if (keys_i.down) begin
        hold_d = hold_inc;
      end else if (keys_i.ok) begin
        hold_d = hold_inc;
        if (at_limit) begin
          res_o.event_code = EV_PUSH;
        end
      end else if (keys_i.push) begin
        hold_d = hold_inc;
        if (at_limit) begin
          res_o.event_code = EV_DOUBLE;
        end
      end else begin
        key_down_d = 1'b0;
        hold_d     = '0;
      end
    end

    window_d = (window_mid != '0) ? window_mid - 16'd1 : window_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q <= 1'b0;
      hold_q     <= '0;
      window_q   <= '0;
    end else if (step_i) begin
      key_down_q <= key_down_d;
      hold_q     <= hold_d;
      window_q   <= window_d;
    end
  end

endmodule

FILE: hdl/key_scan_long_double_press.sv
`timescale 1ns / 1ps

// Key scanner with long press and double press detection. Each beat on in_i is one scan
// tick of four active-low keys and yields exactly one beat on out_o. A new tick is
// accepted every cycle: one input register feeds the combinational event logic, whose
// result lands in the output register, and in_i.ready drops only while both registers
// are full and out_o is held off. The two timing registers are written over cfg_i
// (index 0 long press ticks, index 1 double press window) and must only be changed
// while no tick is in flight.
module key_scan_long_double_press
  import ksl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ksl_key_if.sink   in_i,
  ksl_evt_if.source out_o,
  ksl_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  result_t res;

  logic    in_valid_q;
  keys_t   keys_q;
  logic    out_valid_q;
  result_t res_q;
  logic    advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  ksl_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ksl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .keys_i (keys_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      keys_q.up   <= ~in_i.up_key_n;
      keys_q.down <= ~in_i.down_key_n;
      keys_q.ok   <= ~in_i.ok_key_n;
      keys_q.push <= ~in_i.push_key_n;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_code   = res_q.event_code;
  assign out_o.save_request = res_q.save_request;

endmodule

FILE: hdl/ksl_checker.sv
`timescale 1ns / 1ps

module ksl_checker
  import ksl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_code,
  input logic       save_request
);

  // A stalled result beat stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(event_code) && $stable(save_request))
    else $error("result payload changed while stalled");

  // The save request only comes from an up hold, which never reports an event.
  a_save_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && save_request |-> event_code == EV_NONE)
    else $error("save request together with a key event");

  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> event_code <= EV_DOUBLE)
    else $error("event code out of range");

endmodule

bind key_scan_long_double_press ksl_checker u_ksl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .event_code   (out_o.event_code),
  .save_request (out_o.save_request)
);

FILE: dv/key_scan_long_double_press_tb.sv
`timescale 1ns / 1ps

module key_scan_long_double_press_tb;
  import ksl_pkg::*;

  localparam int unsigned TimeoutCycles = 12_000_000;
  localparam keys_t NoKeys = '0;

  // Scoreboard: tracks the scanner state and holds the events still owed by the block.
  class key_event_tracker;
    logic [TickW-1:0] long_len;
    logic [TickW-1:0] win_len;
    logic [TickW-1:0] hold;
    logic [TickW-1:0] window;
    logic             pressed;
    result_t          expected_events[$];
    int unsigned      mismatches;
    int unsigned      saves_seen;
    int unsigned      code_seen[6];

    function new();
      long_len = LongPressReset;
      win_len  = DoubleWindowReset;
      hold     = '0;
      window   = '0;
      pressed  = 1'b0;
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] value);
      if (idx == CfgLongPress) begin
        long_len = value;
      end else if (idx == CfgDoubleWindow) begin
        win_len = value;
      end
    endfunction

    function void note_scan(keys_t k);
      result_t want;
      logic    any;
      logic    rose;
      any = k.up | k.down | k.ok | k.push;
      want.event_code   = EV_NONE;
      want.save_request = 1'b0;
      if (!pressed && any) begin
        pressed = 1'b1;
        if (k.up) begin
          want.event_code = EV_UP;
        end else if (k.down) begin
          want.event_code = EV_DOWN;
        end else if (k.ok) begin
          want.event_code = EV_OK;
        end else if (window != '0) begin
          want.event_code = EV_DOUBLE;
          window = '0;
        end else begin
          want.event_code = EV_PUSH;
          window = win_len;
        end
      end else if (pressed) begin
        if (!any) begin
          pressed = 1'b0;
          hold    = '0;
        end else begin
          // The hold count sticks at its maximum; long-press events need a real step.
          rose = (hold != HoldMax);
          if (rose) begin
            hold = hold + 1'b1;
          end
          if (k.up) begin
            want.save_request = (hold > long_len);
          end else if (k.down) begin
            want.event_code = EV_NONE;
          end else if (k.ok) begin
            if (rose && hold == long_len) begin
              want.event_code = EV_PUSH;
            end
          end else if (rose && hold == long_len) begin
            want.event_code = EV_DOUBLE;
          end
        end
      end
      if (window != '0) begin
        window = window - 1'b1;
      end
      expected_events.push_back(want);
    endfunction

    function void check_event(logic [2:0] code, logic save);
      result_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected event beat: event_code %0d save_request %0b", code, save);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (code !== want.event_code) begin
        $error("event_code: expected %0d, actual %0d", want.event_code, code);
        mismatches++;
      end
      if (save !== want.save_request) begin
        $error("save_request: expected %0b, actual %0b", want.save_request, save);
        mismatches++;
      end
      if (!$isunknown(code) && code < 6) begin
        code_seen[code]++;
      end
      if (save === 1'b1) begin
        saves_seen++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned scans_sent = 0;
  int unsigned settings_run = 1;
  int unsigned src_idle_odds = 0;
  int unsigned snk_idle_odds = 0;

  key_event_tracker tracker = new();

  // Opening scans, active high (up, down, ok, push): each key alone, the double press
  // and its reset, priority among several keys, and key changes during a hold.
  logic [3:0] opening_scans [24] = '{
    4'b0000, 4'b1000, 4'b0000, 4'b0100, 4'b0000, 4'b0010, 4'b0000, 4'b0001,
    4'b0000, 4'b0001, 4'b0000, 4'b0001, 4'b0001, 4'b0011, 4'b0000, 4'b1111,
    4'b1111, 4'b0111, 4'b0000, 4'b0110, 4'b0000, 4'b0101, 4'b0011, 4'b0000
  };

  ksl_key_if key_if ();
  ksl_evt_if evt_if ();
  ksl_cfg_if cfg_if ();

  key_scan_long_double_press i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (key_if),
    .out_o  (evt_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("key_scan_long_double_press_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      tracker.check_event(evt_if.event_code, evt_if.save_request);
    end
  end

  // Event sink with random stall bursts.
  initial begin
    evt_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (snk_idle_odds != 0 && $urandom_range(0, snk_idle_odds - 1) == 0) begin
        evt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      evt_if.ready <= 1'b1;
    end
  end

  function automatic keys_t random_keys(int unsigned lo);
    logic [3:0] v;
    v = 4'($urandom_range(lo, 15));
    return keys_t'(v);
  endfunction

  function automatic int unsigned pick_idle_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  // Called and returns at a falling edge with no assignment made there yet.
  task automatic scan_tick(input keys_t k);
    if (src_idle_odds != 0 && $urandom_range(0, src_idle_odds - 1) == 0) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    key_if.valid      <= 1'b1;
    key_if.up_key_n   <= ~k.up;
    key_if.down_key_n <= ~k.down;
    key_if.ok_key_n   <= ~k.ok;
    key_if.push_key_n <= ~k.push;
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    tracker.note_scan(k);
    scans_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_and_drain();
    key_if.valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.expected_events.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tracker.note_config(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Usually one press: a release gap, often sized around the double-press window, a first
  // pressed scan, then a hold sometimes steered across the long-press limit; else random scans.
  task automatic press_sequence();
    keys_t       first;
    keys_t       k;
    int unsigned gap;
    int unsigned hold_len;
    int unsigned lim;
    int unsigned win;
    lim = tracker.long_len;
    win = tracker.win_len;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 10)) scan_tick(random_keys(0));
      return;
    end
    case ($urandom_range(0, 2))
      0: gap = $urandom_range(1, 3);
      1: gap = (win > 40) ? $urandom_range(1, 40) : $urandom_range(1, win + 3);
      default: gap = (win > 100) ? $urandom_range(1, 6)
                                 : $urandom_range((win > 2) ? win - 2 : 1, win + 2);
    endcase
    repeat (gap) scan_tick(NoKeys);
    case ($urandom_range(0, 2))
      0: begin
        first = NoKeys;
        first.push = 1'b1;
      end
      1: first = keys_t'(4'(4'b0001 << $urandom_range(0, 3)));
      default: first = random_keys(1);
    endcase
    scan_tick(first);
    if (lim <= 60 && $urandom_range(0, 2) == 0) begin
      hold_len = $urandom_range((lim > 2) ? lim - 2 : 0, lim + 3);
    end else begin
      hold_len = $urandom_range(0, 8);
    end
    repeat (hold_len) begin
      k = ($urandom_range(0, 9) == 0) ? random_keys(1) : first;
      scan_tick(k);
    end
  endtask

  task automatic run_phase(input logic [TickW-1:0] lim, input logic [TickW-1:0] win,
                           input int unsigned budget);
    int unsigned stop_at;
    pause_and_drain();
    write_reg(CfgLongPress, lim);
    write_reg(CfgDoubleWindow, win);
    settings_run++;
    stop_at = scans_sent + budget;
    while (scans_sent < stop_at) press_sequence();
  endtask

  initial begin
    key_if.valid      = 1'b0;
    key_if.up_key_n   = 1'b1;
    key_if.down_key_n = 1'b1;
    key_if.ok_key_n   = 1'b1;
    key_if.push_key_n = 1'b1;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values of both registers.
    foreach (opening_scans[i]) scan_tick(keys_t'(opening_scans[i]));
    src_idle_odds = pick_idle_odds();
    snk_idle_odds = pick_idle_odds();
    while (scans_sent < 250) press_sequence();

    src_idle_odds = 3;
    snk_idle_odds = 12;
    run_phase(16'd1, 16'd1, 150);

    // Largest settings.
    src_idle_odds = pick_idle_odds();
    snk_idle_odds = pick_idle_odds();
    run_phase(HoldMax, HoldMax, 120);

    repeat (3) begin
      src_idle_odds = pick_idle_odds();
      snk_idle_odds = pick_idle_odds();
      run_phase(16'($urandom_range(2, 40)), 16'($urandom_range(2, 60)), 150);
    end

    src_idle_odds = 0;
    snk_idle_odds = 0;
    run_phase(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)), 150);

    pause_and_drain();
    repeat (4) @(posedge clk_i);
    if (tracker.expected_events.size() != 0) begin
      $error("%0d expected events never arrived", tracker.expected_events.size());
    end
    $display("Run covered %0d scan ticks over %0d register settings.",
             scans_sent, settings_run);
    $display("Events: up %0d, down %0d, ok %0d, push %0d, double %0d, save requests %0d.",
             tracker.code_seen[EV_UP], tracker.code_seen[EV_DOWN], tracker.code_seen[EV_OK],
             tracker.code_seen[EV_PUSH], tracker.code_seen[EV_DOUBLE], tracker.saves_seen);
    if (tracker.mismatches == 0 && tracker.expected_events.size() == 0) begin
      $display("key_scan_long_double_press_tb passed");
    end else begin
      $display("key_scan_long_double_press_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ksl_pkg.sv
hdl/ksl_if.sv
hdl/ksl_cfg_regs.sv
hdl/ksl_core.sv
hdl/key_scan_long_double_press.sv
hdl/ksl_checker.sv
dv/key_scan_long_double_press_tb.sv
